@@ rtl/bmavg_pkg.sv @@
// Package with the shared constants and types of the boxcar moving average block.
`default_nettype none

package bmavg_pkg;

   // Fixed field widths.
   localparam int TIME_KEY_BITS = 32;
   localparam int CSR_BITS      = 9;

   // Window size after reset.
   localparam logic [CSR_BITS-1:0] WINDOW_SIZE_RESET = 9'd15;

   // Sequencer states, one-hot.
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_FIN  = 4'b1000
   } bmavg_state_type;

endpackage

`default_nettype wire

@@ rtl/bmavg_req_if.sv @@
// Interface of the sample channel: valid, ready, sample and time key.
`default_nettype none

interface bmavg_req_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                                 valid;
   logic                                 ready;
   logic signed [SAMPLE_BITS-1:0]        sample;
   logic [bmavg_pkg::TIME_KEY_BITS-1:0]  time_key;

   modport source (output valid, output sample, output time_key, input ready);
   modport sink   (input valid, input sample, input time_key, output ready);
endinterface

`default_nettype wire

@@ rtl/bmavg_rsp_if.sv @@
// Interface of the result channel: valid, ready, average, time key and settled flag.
`default_nettype none

interface bmavg_rsp_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                                 valid;
   logic                                 ready;
   logic signed [SAMPLE_BITS-1:0]        average;
   logic [bmavg_pkg::TIME_KEY_BITS-1:0]  time_key_res;
   logic                                 settled;

   modport source (output valid, output average, output time_key_res, output settled,
                   input ready);
   modport sink   (input valid, input average, input time_key_res, input settled,
                   output ready);
endinterface

`default_nettype wire

@@ rtl/boxcar_moving_average_top.sv @@
// Top level of the boxcar moving average: sample ring in RAM, running sum and serial divider.
//
//   Channel   Direction  Handshake            Payload
//   req_ch    in         valid / ready        sample, time_key
//   rsp_ch    out        valid / ready        average, time_key_res, settled
//   csr_*     in         csr_we (no ready)    csr_wdata = window_size
//
// Each item is accepted in IDLE while the ring RAM is read, then READ updates the sum and
// writes the sample back, DIV runs the bit-serial divider over SUM_W quotient bits and
// FIN loads the output register.
// Reset clears the control state at once; the ring is never swept, since the fill count
// marks entries not yet written in the current window as zero.
// A stalled result waits in the output register while the next item is already accepted.
`default_nettype none

module boxcar_moving_average_top #(
   parameter int WINDOW_MAX  = 256,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   bmavg_req_if.sink                              req_ch,
   bmavg_rsp_if.source                            rsp_ch,
   input  wire logic                              csr_we,
   input  wire logic [bmavg_pkg::CSR_BITS-1:0]    csr_wdata
);

   localparam int PTR_W  = $clog2(WINDOW_MAX);
   localparam int WIN_W  = $clog2(WINDOW_MAX + 1);
   localparam int CNT_W  = $clog2(WINDOW_MAX + 2);
   localparam int SUM_W  = SAMPLE_BITS + PTR_W;
   localparam int DCNT_W = $clog2(SUM_W);
   localparam int CMP_W  = (WIN_W > bmavg_pkg::CSR_BITS) ? WIN_W : bmavg_pkg::CSR_BITS;
   localparam int TK_W   = bmavg_pkg::TIME_KEY_BITS;

   // Control registers.
   bmavg_pkg::bmavg_state_type state_ff, state_in;
   logic [bmavg_pkg::CSR_BITS-1:0] window_size_ff;
   logic signed [SUM_W-1:0]        sum_ff, sum_in;
   logic [PTR_W-1:0]               pos_ff, pos_in;
   logic [CNT_W-1:0]               seen_ff, seen_in;
   logic [DCNT_W-1:0]              dcnt_ff, dcnt_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic signed [SAMPLE_BITS-1:0]  sample_ff;
   logic [TK_W-1:0]                tkey_ff;
   logic                           settled_ff, settled_in;
   logic [WIN_W-1:0]               rem_ff, rem_in;
   logic [SUM_W-1:0]               quo_ff, quo_in;
   logic                           neg_ff, neg_in;
   logic signed [SAMPLE_BITS-1:0]  avg_out_ff;
   logic [TK_W-1:0]                tkey_out_ff;
   logic                           settled_out_ff;

   logic [SAMPLE_BITS-1:0]         ram_rdata;
   logic signed [SAMPLE_BITS-1:0]  old_sample;
   logic [WIN_W-1:0]               win_eff;
   logic [WIN_W-1:0]               pos_inc;
   logic [WIN_W:0]                 cand;
   logic                           cand_ge;
   logic [SUM_W-1:0]               quo_neg;
   logic                           req_fire;
   logic                           out_load;
   logic                           ram_we;

   // Effective window: zero counts as one, large values clamp to the ring depth.
   always_comb begin
      if (window_size_ff == '0) begin
         win_eff = WIN_W'(1);
      end else if (CMP_W'(window_size_ff) > CMP_W'(WINDOW_MAX)) begin
         win_eff = WIN_W'(WINDOW_MAX);
      end else begin
         win_eff = WIN_W'(window_size_ff);
      end
   end

   assign req_ch.ready = (state_ff == bmavg_pkg::ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign out_load     = (state_ff == bmavg_pkg::ST_FIN) && (!rsp_valid_ff || rsp_ch.ready);
   assign ram_we       = (state_ff == bmavg_pkg::ST_READ);

   // Ring memory: read at the write position, written back in the READ state.
   bmavg_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (WINDOW_MAX)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (pos_ff),
      .wr_data (sample_ff),
      .rd_addr (pos_ff),
      .rd_data (ram_rdata)
   );

   // Entries not yet written since the last clear read as zero.
   assign old_sample = (CNT_W'(seen_ff) < CNT_W'(win_eff)) ? '0 : $signed(ram_rdata);
   assign pos_inc    = WIN_W'(pos_ff) + WIN_W'(1);

   // One restoring divide step.
   assign cand    = {rem_ff, quo_ff[SUM_W-1]};
   assign cand_ge = (cand >= {1'b0, win_eff});
   assign quo_neg = SUM_W'(0) - quo_ff;

   // Sequencer and state update.
   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      pos_in       = pos_ff;
      seen_in      = seen_ff;
      dcnt_in      = dcnt_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      neg_in       = neg_ff;
      settled_in   = settled_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         bmavg_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = bmavg_pkg::ST_READ;
            end
         end
         bmavg_pkg::ST_READ: begin
            sum_in = sum_ff - SUM_W'(old_sample) + SUM_W'(sample_ff);
            if (pos_inc >= win_eff) begin
               pos_in = '0;
            end else begin
               pos_in = PTR_W'(pos_inc);
            end
            if (CNT_W'(seen_ff) <= CNT_W'(win_eff)) begin
               seen_in = seen_ff + CNT_W'(1);
            end
            settled_in = (CNT_W'(seen_in) > CNT_W'(win_eff));
            neg_in     = sum_in[SUM_W-1];
            quo_in     = sum_in[SUM_W-1] ? (SUM_W'(0) - sum_in) : sum_in;
            rem_in     = '0;
            dcnt_in    = DCNT_W'(SUM_W - 1);
            state_in   = bmavg_pkg::ST_DIV;
         end
         bmavg_pkg::ST_DIV: begin
            rem_in  = cand_ge ? WIN_W'(cand - {1'b0, win_eff}) : WIN_W'(cand);
            quo_in  = {quo_ff[SUM_W-2:0], cand_ge};
            dcnt_in = dcnt_ff - DCNT_W'(1);
            if (dcnt_ff == '0) begin
               state_in = bmavg_pkg::ST_FIN;
            end
         end
         bmavg_pkg::ST_FIN: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               state_in     = bmavg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bmavg_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers with reset; a window write clears sum, position and count.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= bmavg_pkg::ST_IDLE;
         window_size_ff <= bmavg_pkg::WINDOW_SIZE_RESET;
         sum_ff         <= '0;
         pos_ff         <= '0;
         seen_ff        <= '0;
         dcnt_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dcnt_ff      <= dcnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            window_size_ff <= csr_wdata;
            sum_ff         <= '0;
            pos_ff         <= '0;
            seen_ff        <= '0;
         end else begin
            sum_ff  <= sum_in;
            pos_ff  <= pos_in;
            seen_ff <= seen_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         sample_ff <= req_ch.sample;
         tkey_ff   <= req_ch.time_key;
      end
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      neg_ff     <= neg_in;
      settled_ff <= settled_in;
      if (out_load) begin
         avg_out_ff     <= neg_ff ? SAMPLE_BITS'(quo_neg) : SAMPLE_BITS'(quo_ff);
         tkey_out_ff    <= tkey_ff;
         settled_out_ff <= settled_ff;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.average      = avg_out_ff;
   assign rsp_ch.time_key_res = tkey_out_ff;
   assign rsp_ch.settled      = settled_out_ff;

endmodule

`default_nettype wire

@@ rtl/bmavg_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module bmavg_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench of the boxcar moving average: a directed table, then random window phases.
module tb_top;

   localparam int WIN_MAX     = 256;
   localparam int SAMPLE_W    = 16;
   localparam int CSR_W       = bmavg_pkg::CSR_BITS;
   localparam int KEY_W       = bmavg_pkg::TIME_KEY_BITS;
   localparam int IDLE_LIMIT  = 3000;
   localparam int TAIL_CYCLES = 60;
   localparam int PLAN_ROWS   = 26;
   localparam int NUM_PHASES  = 12;

   typedef enum bit {ROW_ITEM, ROW_WINDOW} row_kind_type;

   // One row of the directed table: either a window write or a sample item.
   typedef struct {
      row_kind_type               kind;
      logic [CSR_W-1:0]           window;
      logic signed [SAMPLE_W-1:0] sample;
      logic [KEY_W-1:0]           key;
      bit                         known;
      logic signed [SAMPLE_W-1:0] avg;
      bit                         settled;
   } plan_row_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] average;
      logic [KEY_W-1:0]           time_key;
      logic                       settled;
   } avg_result_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_we;
   logic [CSR_W-1:0] csr_wdata;

   bmavg_req_if #(.SAMPLE_BITS(SAMPLE_W)) req_bus ();
   bmavg_rsp_if #(.SAMPLE_BITS(SAMPLE_W)) rsp_bus ();

   boxcar_moving_average_top #(
      .WINDOW_MAX  (WIN_MAX),
      .SAMPLE_BITS (SAMPLE_W)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // Shadow of the filter state.
   logic [CSR_W-1:0]           window_reg;
   logic signed [SAMPLE_W-1:0] history [WIN_MAX];
   int                         window_sum;
   int                         slot;
   int                         fill;

   avg_result_type pending_averages [$];
   int             mismatches;
   int             items_sent;
   int             results_checked;
   int             window_writes;
   int             quiet_cycles;
   bit             steady;

   // Window writes, extremes and truncation toward zero; expected values typed where obvious.
   plan_row_type directed_plan [PLAN_ROWS] = '{
      '{ROW_ITEM,   9'd0,   16'sd0,     32'h0000_0000, 1'b1, 16'sd0,     1'b0},
      '{ROW_ITEM,   9'd0,   16'sd32767, 32'hFFFF_FFFF, 1'b1, 16'sd2184,  1'b0},
      '{ROW_ITEM,   9'd0,   16'sh8000,  32'h5A5A_5A5A, 1'b1, 16'sd0,     1'b0},
      '{ROW_WINDOW, 9'd1,   16'sd0,     32'h0,         1'b0, 16'sd0,     1'b0},
      '{ROW_ITEM,   9'd0,   16'sd32767, 32'hA5A5_A5A5, 1'b1, 16'sd32767, 1'b0},
      '{ROW_ITEM,   9'd0,   16'sh8000,  32'h0000_0001, 1'b1, 16'sh8000,  1'b1},
      '{ROW_ITEM,   9'd0,   -16'sd1,    32'h8000_0000, 1'b1, -16'sd1,    1'b1},
      '{ROW_WINDOW, 9'd0,   16'sd0,     32'h0,         1'b0, 16'sd0,     1'b0},
      '{ROW_ITEM,   9'd0,   16'sd5,     32'h0000_0002, 1'b1, 16'sd5,     1'b0},
      '{ROW_ITEM,   9'd0,   -16'sd7,    32'h0000_0003, 1'b1, -16'sd7,    1'b1},
      '{ROW_WINDOW, 9'd2,   16'sd0,     32'h0,         1'b0, 16'sd0,     1'b0},
      '{ROW_ITEM,   9'd0,   16'sd32767, 32'h0000_0010, 1'b1, 16'sd16383, 1'b0},
      '{ROW_ITEM,   9'd0,   16'sd32767, 32'h0000_0011, 1'b1, 16'sd32767, 1'b0},
      '{ROW_ITEM,   9'd0,   16'sh8000,  32'h0000_0012, 1'b1, 16'sd0,     1'b1},
      '{ROW_ITEM,   9'd0,   16'sh8000,  32'h0000_0013, 1'b1, 16'sh8000,  1'b1},
      '{ROW_WINDOW, 9'd2,   16'sd0,     32'h0,         1'b0, 16'sd0,     1'b0},
      '{ROW_ITEM,   9'd0,   16'sd4,     32'h0000_0020, 1'b1, 16'sd2,     1'b0},
      '{ROW_ITEM,   9'd0,   -16'sd3,    32'h0000_0021, 1'b1, 16'sd0,     1'b0},
      '{ROW_WINDOW, 9'd511, 16'sd0,     32'h0,         1'b0, 16'sd0,     1'b0},
      '{ROW_ITEM,   9'd0,   16'sh8000,  32'h0000_0030, 1'b1, -16'sd128,  1'b0},
      '{ROW_ITEM,   9'd0,   -16'sd1,    32'h0000_0031, 1'b1, -16'sd128,  1'b0},
      '{ROW_ITEM,   9'd0,   16'sd32767, 32'h0000_0032, 1'b0, 16'sd0,     1'b0},
      '{ROW_WINDOW, 9'd257, 16'sd0,     32'h0,         1'b0, 16'sd0,     1'b0},
      '{ROW_ITEM,   9'd0,   16'sd12345, 32'h1234_5678, 1'b0, 16'sd0,     1'b0},
      '{ROW_ITEM,   9'd0,   -16'sd20000, 32'h8765_4321, 1'b0, 16'sd0,    1'b0},
      '{ROW_WINDOW, 9'd256, 16'sd0,     32'h0,         1'b0, 16'sd0,     1'b0}
   };

   // Any window write empties the ring and restarts the warm-up.
   function automatic void clear_history();
      foreach (history[i]) history[i] = '0;
      window_sum = 0;
      slot       = 0;
      fill       = 0;
   endfunction

   // Pushes one sample through the shadow ring and returns the average it yields.
   function automatic avg_result_type advance_average(input logic signed [SAMPLE_W-1:0] s,
                                                      input logic [KEY_W-1:0] key);
      int             w;
      int             pos;
      avg_result_type r;
      w = (window_reg == 0) ? 1 : ((window_reg > WIN_MAX) ? WIN_MAX : int'(window_reg));
      pos = (slot >= w) ? 0 : slot;
      window_sum -= history[pos];
      history[pos] = s;
      window_sum += s;
      pos++;
      slot = (pos >= w) ? 0 : pos;
      if (fill <= w) fill++;
      r.average  = SAMPLE_W'(window_sum / w);
      r.time_key = key;
      r.settled  = (fill > w);
      return r;
   endfunction

   // Samples lean toward the extremes and toward values near zero.
   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(7))
         0: pick_sample = 16'sh8000;
         1: pick_sample = 16'sh7FFF;
         2: pick_sample = SAMPLE_W'(int'($urandom_range(6)) - 3);
         default: pick_sample = SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic logic [KEY_W-1:0] pick_key();
      case ($urandom_range(15))
         0: pick_key = '0;
         1: pick_key = '1;
         default: pick_key = $urandom;
      endcase
   endfunction

   // Random window sizes: mostly short, some long, some outside the legal range.
   function automatic logic [CSR_W-1:0] pick_window();
      case ($urandom_range(3))
         0, 1: pick_window = CSR_W'($urandom_range(16, 1));
         2: pick_window = CSR_W'($urandom_range(256, 17));
         default: pick_window = CSR_W'($urandom_range(511, 0));
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at result %0d: %s", results_checked, msg);
      mismatches++;
   endtask

   // Presents one item, waits for its acceptance and records the expected average.
   task automatic send_item(input logic signed [SAMPLE_W-1:0] s,
                            input logic [KEY_W-1:0] key,
                            input bit known,
                            input logic signed [SAMPLE_W-1:0] avg,
                            input bit settled);
      avg_result_type r;
      req_bus.valid    <= 1'b1;
      req_bus.sample   <= s;
      req_bus.time_key <= key;
      do @(posedge clock); while (!req_bus.ready);
      r = advance_average(s, key);
      if (known) begin
         r.average = avg;
         r.settled = settled;
      end
      pending_averages.push_back(r);
      items_sent++;
   endtask

   task automatic sender_pause();
      int n;
      n = $urandom_range(40, 1);
      req_bus.valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (pending_averages.size() != 0) @(posedge clock);
   endtask

   // The window is written only once every average has come out.
   task automatic write_window(input logic [CSR_W-1:0] w);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= w;
      @(posedge clock);
      csr_we     <= 1'b0;
      window_reg = w;
      clear_history();
      window_writes++;
      @(posedge clock);
   endtask

   // Result side stalls now and then, except during the steady stretch.
   always @(posedge clock) begin
      rsp_bus.ready <= steady || ($urandom_range(99) >= 6);
   end

   // Each accepted result is compared with the oldest expectation.
   always @(posedge clock) begin
      avg_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_averages.size() == 0) begin
            report_mismatch($sformatf("average %0d with nothing expected", rsp_bus.average));
         end else begin
            want = pending_averages.pop_front();
            if (rsp_bus.average !== want.average)
               report_mismatch($sformatf("average %0d, expected %0d",
                                         rsp_bus.average, want.average));
            if (rsp_bus.time_key_res !== want.time_key)
               report_mismatch($sformatf("time key %h, expected %h",
                                         rsp_bus.time_key_res, want.time_key));
            if (rsp_bus.settled !== want.settled)
               report_mismatch($sformatf("settled %b, expected %b",
                                         rsp_bus.settled, want.settled));
         end
         results_checked++;
      end
   end

   // Watchdog on cycles with no item moving on either channel.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("Timeout after %0d cycles without progress.", IDLE_LIMIT);
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int                         count;
      int                         total;
      logic signed [SAMPLE_W-1:0] s;
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_wdata        = '0;
      req_bus.valid    = 1'b0;
      req_bus.sample   = '0;
      req_bus.time_key = '0;
      steady           = 1'b0;
      items_sent       = 0;
      window_writes    = 0;
      total            = 0;
      window_reg       = bmavg_pkg::WINDOW_SIZE_RESET;
      clear_history();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed table.
      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == ROW_WINDOW) begin
            write_window(directed_plan[i].window);
         end else begin
            send_item(directed_plan[i].sample, directed_plan[i].key, directed_plan[i].known,
                      directed_plan[i].avg, directed_plan[i].settled);
         end
      end

      // Random phases: a full window that settles at the top, then assorted sizes.
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: write_window(9'd256);
            1: write_window(9'd511);
            2: write_window(9'd3);
            3: write_window(9'd1);
            4: write_window(9'd0);
            default: write_window(pick_window());
         endcase
         count = (p == 0) ? 280 : 33;
         for (int n = 0; n < count; n++) begin
            steady = (total >= 100 && total < 250);
            s = (p == 0 && n < 265) ? 16'sh7FFF : pick_sample();
            send_item(s, pick_key(), 1'b0, '0, 1'b0);
            total++;
            // Hold the sender once until the block has emptied out.
            if (p == 2 && n == 16) begin
               wait_drained();
            end else if (!steady && $urandom_range(99) < 10) begin
               sender_pause();
            end
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Checked %0d averages from %0d samples across %0d window writes.",
               results_checked, items_sent, window_writes);
      $display("Windows of zero, one, the maximum and above it were run; %0d mismatches.",
               mismatches);
      if (mismatches == 0 && pending_averages.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
